FILE: rtl/assert_macros.svh
// Assertion macros used by the positional list core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define PLIM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the following cycle.
`define PLIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plim_pkg.sv
// Types and constants of the positional list core.
package plim_pkg;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  // Compare width for positions and counts (covers counts up to 127).
  localparam int CMP_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FWD    = 2'd2,
    CMD_REV    = 2'd3
  } plim_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BOUNDS = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_EMPTY  = 2'd3
  } plim_status_t;

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_INS  = 3'd1,
    OP_DEL  = 3'd2,
    OP_ROTL = 3'd3,
    OP_ROTR = 3'd4
  } plim_cell_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    plim_cell_op_t          op;
    logic [CMP_W-1:0]       pos;
    logic [CMP_W-1:0]       last_idx;
  } plim_cell_ctl_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } plim_fsm_t;

endpackage

FILE: rtl/plim_if.sv
// Handshake interfaces for the command and result channels.
interface plim_in_if;
  import plim_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface plim_out_if;
  import plim_pkg::*;
  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    value_res;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

FILE: rtl/plim_cell.sv
// One list slot: holds a value and shifts or rotates with its neighbors.
module plim_cell #(
  parameter int IDX = 0,
  parameter int W   = 16
) (
  input  logic                    clk,
  input  plim_pkg::plim_cell_ctl_t ctl,
  input  logic [W-1:0]            ins_val,
  input  logic [W-1:0]            left_val,
  input  logic [W-1:0]            right_val,
  input  logic [W-1:0]            head_val,
  input  logic [W-1:0]            tail_val,
  output logic [W-1:0]            q,
  output logic [W-1:0]            tail_part
);
  import plim_pkg::*;

  localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (IDX_C > ctl.pos) begin
          data_nxt = left_val;
        end else if (IDX_C == ctl.pos) begin
          data_nxt = ins_val;
        end
      end
      OP_DEL: begin
        if (IDX_C >= ctl.pos) begin
          data_nxt = right_val;
        end
      end
      OP_ROTL: begin
        // tail slot wraps around to take the head
        if (IDX_C == ctl.last_idx) begin
          data_nxt = head_val;
        end else if (IDX_C < ctl.last_idx) begin
          data_nxt = right_val;
        end
      end
      OP_ROTR: begin
        if (IDX == 0) begin
          data_nxt = tail_val;
        end else if (IDX_C <= ctl.last_idx) begin
          data_nxt = left_val;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q         = data_r;
  assign tail_part = (IDX_C == ctl.last_idx) ? data_r : '0;

endmodule

FILE: rtl/positional_list_insert_delete_core.sv
// Positional list core: ordered list in a chain of slot cells.
// Command channel in_if carries cmd, position and value; result channel out_if
// carries value_res, status and last. A legal insert or delete changes the
// chain in the cycle the command is accepted (every slot at or past the
// position shifts by one); each insert or delete gives one status result,
// registered and visible the next cycle. Forward and reverse dumps rotate the
// occupied slots by one each cycle, emitting the head (forward) or the tail
// (reverse), so a dump of N elements gives N results at one per cycle and
// leaves the list as it was; an empty list gives one result with status empty.
// Insert, delete and an empty dump load their result straight into the result
// register; a non-empty dump first enters the dump state, and the dump state
// loads each result in turn. Insert and delete are taken one per cycle; a dump
// holds the command channel until the chain has rotated through all N
// elements. A stall on out_if freezes the chain and the dump counter, and
// in_if.ready stays low while the result register holds an untaken result.
// Synchronous reset empties the list and clears the result valid; slot
// contents are not cleared and are never read beyond the element count.
`include "assert_macros.svh"

module positional_list_insert_delete_core #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  plim_in_if.sink     in_if,
  plim_out_if.source  out_if
);
  import plim_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SW    = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

  plim_fsm_t             state_r, state_nxt;
  logic                  dir_rev_r, dir_rev_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]      out_value_r, out_value_nxt;
  plim_status_t          out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  plim_cell_ctl_t        ctl;
  logic [SW-1:0]         cell_q [CAPACITY];
  logic [SW-1:0]         tail_part [CAPACITY];
  logic [SW-1:0]         head_val;
  logic [SW-1:0]         tail_val;
  logic [SW-1:0]         ins_val;

  logic                  out_free;
  logic                  in_ready;
  logic                  accept;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  ins_take;
  logic                  remain_ok;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign accept   = in_if.valid && in_ready;
  assign pos_ext  = CMP_W'(in_if.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign ins_val  = in_if.value[SW-1:0];
  assign head_val = cell_q[0];

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_val = tail_val | tail_part[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [SW-1:0] left_v;
    logic [SW-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end
    plim_cell #(.IDX(g), .W(SW)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_val   (ins_val),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (head_val),
      .tail_val  (tail_val),
      .q         (cell_q[g]),
      .tail_part (tail_part[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    dir_rev_nxt    = dir_rev_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ctl.op         = OP_HOLD;
    ctl.pos        = pos_ext;
    ctl.last_idx   = cnt_ext - CMP_W'(1);

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STATUS_OK;
          case (plim_cmd_t'(in_if.cmd))
            CMD_INSERT: begin
              if (pos_ext > cnt_ext) begin
                out_status_nxt = STATUS_BOUNDS;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                ctl.op    = OP_INS;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                out_status_nxt = STATUS_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                out_status_nxt = STATUS_BOUNDS;
              end else begin
                ctl.op    = OP_DEL;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              if (count_r == '0) begin
                out_status_nxt = STATUS_EMPTY;
              end else begin
                // results come from the dump state, one per cycle while out_if is not stalled
                out_valid_nxt = 1'b0;
                state_nxt     = FSM_DUMP;
                dir_rev_nxt   = (plim_cmd_t'(in_if.cmd) == CMD_REV);
                remain_nxt    = count_r;
              end
            end
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_last_nxt   = (remain_r == CNT_W'(1));
          out_value_nxt  = dir_rev_r ? VAL_W'(tail_val) : VAL_W'(head_val);
          ctl.op         = dir_rev_r ? OP_ROTR : OP_ROTL;
          remain_nxt     = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      dir_rev_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      dir_rev_r   <= dir_rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.value_res = out_value_r;
  assign out_if.status    = out_status_r;
  assign out_if.last      = out_last_r;

  assign ins_take  = accept && (in_if.cmd == CMD_INSERT) && (pos_ext <= cnt_ext) &&
                     (count_r != CNT_W'(CAPACITY));
  assign remain_ok = (remain_r != '0) && (remain_r <= count_r);

  `PLIM_ASSERT_SAME(a_count_cap, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `PLIM_ASSERT_SAME(a_dump_remain, state_r == FSM_DUMP, remain_ok, "dump counter out of range")
  `PLIM_ASSERT_NEXT(a_ins_count, ins_take, count_r == $past(count_r) + CNT_W'(1), "insert lost")
  `PLIM_ASSERT_SAME(a_dump_blocks, state_r == FSM_DUMP, !in_if.ready, "command taken during dump")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the positional list core: driver, monitor, list predictor.
`timescale 1ns / 1ps

module tb_top;
  import plim_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 16;
  localparam int RESET_CYCLES = 8;
  localparam int TAIL_ITEMS   = 20;    // no idling once the backlog is this short
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    plim_cmd_t        cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] value_res;
    plim_status_t     status;
    logic             last;
  } list_resp_t;

  logic clk;
  logic rst_n;

  plim_in_if  in_if();
  plim_out_if out_if();

  positional_list_insert_delete_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  list_cmd_t        cmd_backlog[$];
  list_resp_t       awaited_responses[$];
  logic [VAL_W-1:0] shadow_list[$];

  int gen_count = 0;             // list length as the stimulus generator sees it
  int cycle_count = 0;
  int fail_count = 0;
  int checked_count = 0;
  int max_depth = 0;
  int cmd_seen[4];
  int status_seen[4];
  int gap_left = 0;
  int stall_left = 0;
  logic in_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor: applies one accepted command to the shadow list and queues its results.
  task automatic predict_list_response(plim_cmd_t op, int pos, logic [VAL_W-1:0] val);
    list_resp_t r;
    int n;
    n = shadow_list.size();
    r.value_res = '0;
    r.status    = STATUS_OK;
    r.last      = 1'b1;
    case (op)
      CMD_INSERT: begin
        if (pos > n) begin
          r.status = STATUS_BOUNDS;
        end else if (n >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_list.insert(pos, val);
        end
        awaited_responses.push_back(r);
      end
      CMD_DELETE: begin
        if (n == 0) begin
          r.status = STATUS_EMPTY;
        end else if (pos >= n) begin
          r.status = STATUS_BOUNDS;
        end else begin
          shadow_list.delete(pos);
        end
        awaited_responses.push_back(r);
      end
      default: begin
        if (n == 0) begin
          r.status = STATUS_EMPTY;
          awaited_responses.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.value_res = shadow_list[(op == CMD_FWD) ? i : n - 1 - i];
            r.last      = (i == n - 1);
            awaited_responses.push_back(r);
          end
        end
      end
    endcase
    if (shadow_list.size() > max_depth) max_depth = shadow_list.size();
  endtask

  // Generator side: queues a command and tracks the list length it will produce.
  task automatic queue_cmd(plim_cmd_t op, int pos, int val);
    list_cmd_t c;
    c.cmd      = op;
    c.position = pos[POS_W-1:0];
    c.value    = val[VAL_W-1:0];
    cmd_backlog.push_back(c);
    if (op == CMD_INSERT && pos <= gen_count && gen_count < CAPACITY) gen_count++;
    else if (op == CMD_DELETE && gen_count > 0 && pos < gen_count) gen_count--;
  endtask

  function automatic int rand_value();
    return $urandom_range(0, (1 << VAL_W) - 1);
  endfunction

  // Command driver: holds the item until taken, random gaps between items.
  always @(negedge clk) begin
    list_cmd_t nxt;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.cmd      <= CMD_INSERT;
      in_if.position <= '0;
      in_if.value    <= '0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        in_if.valid    <= 1'b1;
        in_if.cmd      <= nxt.cmd;
        in_if.position <= nxt.position;
        in_if.value    <= nxt.value;
        if (cmd_backlog.size() >= TAIL_ITEMS && $urandom_range(0, 4) == 0)
          gap_left <= $urandom_range(1, 10);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: ready drops in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (cmd_backlog.size() >= TAIL_ITEMS && $urandom_range(0, 6) == 0)
        stall_left <= $urandom_range(1, 10);
    end
  end

  // Monitor: predicts on accepted commands, then checks any accepted result.
  always @(posedge clk) begin
    list_resp_t exp_r;
    cycle_count <= cycle_count + 1;
    in_fire     <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        cmd_seen[in_if.cmd]++;
        predict_list_response(plim_cmd_t'(in_if.cmd), int'(in_if.position), in_if.value);
      end
      if (out_if.valid && out_if.ready) begin
        checked_count++;
        if (awaited_responses.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: value_res %h status %0d last %0b",
                     out_if.value_res, out_if.status, out_if.last);
        end else begin
          exp_r = awaited_responses.pop_front();
          status_seen[exp_r.status]++;
          if (out_if.value_res !== exp_r.value_res || out_if.status !== exp_r.status ||
              out_if.last !== exp_r.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch on result %0d: value_res %h/%h status %0d/%0d last %0b/%0b",
                       checked_count, exp_r.value_res, out_if.value_res, exp_r.status,
                       out_if.status, exp_r.last, out_if.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, awaited_responses.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int sel;
    int pos;
    rst_n = 1'b0;

    // directed: empty list corners, bounds checks, head/middle/tail edits
    queue_cmd(CMD_FWD, 0, 0);
    queue_cmd(CMD_REV, 5, 16'hBEEF);
    queue_cmd(CMD_DELETE, 63, 0);          // empty wins over bounds
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_INSERT, 1, 16'h1111);    // past the end
    queue_cmd(CMD_INSERT, 63, 16'hFFFF);
    queue_cmd(CMD_INSERT, 0, 16'h0000);
    queue_cmd(CMD_INSERT, 1, 16'hFFFF);    // append
    queue_cmd(CMD_INSERT, 0, 16'hA5A5);    // new head
    queue_cmd(CMD_INSERT, 3, 16'h5A5A);
    queue_cmd(CMD_INSERT, 2, 16'h1234);    // middle
    queue_cmd(CMD_FWD, 0, 0);
    queue_cmd(CMD_REV, 0, 0);
    queue_cmd(CMD_DELETE, 5, 0);           // position equal to count
    queue_cmd(CMD_DELETE, 63, 0);
    queue_cmd(CMD_DELETE, 2, 0);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_DELETE, 2, 0);           // tail
    queue_cmd(CMD_FWD, 0, 0);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_DELETE, 0, 0);           // list goes empty
    queue_cmd(CMD_REV, 0, 0);
    queue_cmd(CMD_INSERT, 0, 16'h8001);

    // fill to capacity with random positions, then hit the full and bounds paths
    while (gen_count < CAPACITY) queue_cmd(CMD_INSERT, $urandom_range(0, gen_count), rand_value());
    queue_cmd(CMD_INSERT, CAPACITY, rand_value());
    queue_cmd(CMD_INSERT, CAPACITY + 1, rand_value());
    queue_cmd(CMD_INSERT, 0, rand_value());
    queue_cmd(CMD_FWD, 0, 0);
    queue_cmd(CMD_REV, 0, 0);
    queue_cmd(CMD_DELETE, CAPACITY - 1, 0);
    queue_cmd(CMD_DELETE, CAPACITY, 0);

    // random mix: mostly legal edits, some dumps and some noise
    repeat (57) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        queue_cmd(CMD_INSERT, $urandom_range(0, gen_count), rand_value());
      end else if (sel < 65) begin
        pos = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
        queue_cmd(CMD_DELETE, pos, rand_value());
      end else if (sel < 75) begin
        queue_cmd(($urandom_range(0, 1) == 0) ? CMD_FWD : CMD_REV, $urandom_range(0, 63),
                  rand_value());
      end else begin
        queue_cmd(plim_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63), rand_value());
      end
    end
    queue_cmd(CMD_FWD, 0, 0);
    queue_cmd(CMD_REV, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_if.valid) @(negedge clk);
    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("commands: %0d insert, %0d delete, %0d forward dump, %0d reverse dump",
             cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_FWD], cmd_seen[CMD_REV]);
    $display("results checked: %0d (ok %0d, bounds %0d, full %0d, empty %0d), peak length %0d",
             checked_count, status_seen[STATUS_OK], status_seen[STATUS_BOUNDS],
             status_seen[STATUS_FULL], status_seen[STATUS_EMPTY], max_depth);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/plim_pkg.sv
rtl/plim_if.sv
rtl/plim_cell.sv
rtl/positional_list_insert_delete_core.sv
tb/sv/tb_top.sv
